>>> hw/rtl/kpd_pkg.sv
// Shared types, widths and constants of the keypad scanner.
`default_nettype none

package kpd_pkg;

    localparam int LINE_BITS   = 4;
    localparam int COLUMN_BITS = 4;
    localparam int TIMER_W     = 16;
    localparam int CODE_W      = 8;
    localparam int KEY_W       = 4;
    localparam int CFG_IDX_W   = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TARGET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SHORT_DOWN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SHORT_UP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_LONG_DOWN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_LONG_UP    = 3'd6;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_DEBOUNCE = 5'b00010,
        ST_DECODE   = 5'b00100,
        ST_HELD     = 5'b01000,
        ST_RELEASE  = 5'b10000
    } t_step;

    typedef struct packed {
        logic [TIMER_W-1:0] filter_ticks;
        logic [TIMER_W-1:0] long_target;
        logic [TIMER_W-1:0] long_limit;
        logic [CODE_W-1:0]  code_short_down;
        logic [CODE_W-1:0]  code_short_up;
        logic [CODE_W-1:0]  code_long_down;
        logic [CODE_W-1:0]  code_long_up;
    } t_cfg;

    typedef struct packed {
        logic              event_valid;
        logic [CODE_W-1:0] event_code;
        logic [KEY_W-1:0]  key_index;
        logic              read_lines_mode;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/kpd_decode.sv
// Line/column code to key number table.
`default_nettype none

module kpd_decode
    import kpd_pkg::*;
(
    input  wire logic [LINE_BITS-1:0]   i_lines,
    input  wire logic [COLUMN_BITS-1:0] i_columns,
    output logic                        o_hit,
    output logic [KEY_W-1:0]            o_key
);

    always_comb begin
        o_hit = 1'b1;
        unique case ({i_lines, i_columns})
            8'h88: o_key = 4'd0;
            8'h48: o_key = 4'd1;
            8'h28: o_key = 4'd2;
            8'h18: o_key = 4'd3;
            8'h84: o_key = 4'd4;
            8'h44: o_key = 4'd5;
            8'h24: o_key = 4'd6;
            8'h14: o_key = 4'd7;
            8'h82: o_key = 4'd8;
            8'h42: o_key = 4'd9;
            8'h22: o_key = 4'd10;
            8'h12: o_key = 4'd11;
            8'h81: o_key = 4'd12;
            8'h41: o_key = 4'd13;
            // two-key combinations
            8'h38: o_key = 4'd10;
            8'hc4: o_key = 4'd11;
            8'h34: o_key = 4'd12;
            8'hc2: o_key = 4'd13;
            8'hac: o_key = 4'd14;
            8'h54: o_key = 4'd15;
            default: begin
                o_hit = 1'b0;
                o_key = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/kpd_fsm.sv
// Scan state machine: debounce timer, decode, hold counter and event selection.
`default_nettype none

module kpd_fsm
    import kpd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_fire,
    input  wire logic                   i_command,
    input  wire logic [COLUMN_BITS-1:0] i_column_bits,
    input  wire logic [LINE_BITS-1:0]   i_line_bits,
    input  wire t_cfg                   i_cfg,
    output t_result                     o_result
);

    t_step                   r_step, n_step;
    logic [TIMER_W-1:0]      r_timer, n_timer;
    logic [TIMER_W-1:0]      r_hold, n_hold;
    logic [KEY_W-1:0]        r_key, n_key;
    logic [LINE_BITS-1:0]    r_lines, n_lines;
    logic [COLUMN_BITS-1:0]  r_cols, n_cols;
    logic                    r_pressed, n_pressed;
    logic                    r_mode, n_mode;

    logic                    dec_hit;
    logic [KEY_W-1:0]        dec_key;
    logic                    expired;
    logic [TIMER_W:0]        wait_sum;
    logic [TIMER_W-1:0]      release_wait;
    logic [TIMER_W-1:0]      hold_inc;
    logic                    ev_valid;
    logic [CODE_W-1:0]       ev_code;

    kpd_decode u_decode (
        .i_lines   (i_line_bits),
        .i_columns (r_cols),
        .o_hit     (dec_hit),
        .o_key     (dec_key)
    );

    assign expired      = (r_timer == '0);
    assign wait_sum     = {1'b0, i_cfg.filter_ticks} + {1'b0, i_cfg.filter_ticks};
    assign release_wait = wait_sum[TIMER_W] ? {TIMER_W{1'b1}} : wait_sum[TIMER_W-1:0];
    assign hold_inc     = r_hold + 1'b1;

    always_comb begin
        n_step    = r_step;
        n_timer   = r_timer;
        n_hold    = r_hold;
        n_key     = r_key;
        n_lines   = r_lines;
        n_cols    = r_cols;
        n_pressed = r_pressed;
        n_mode    = r_mode;
        ev_valid  = 1'b0;
        ev_code   = '0;

        if (i_command == CMD_TICK) begin
            if (!expired) begin
                n_timer = r_timer - 1'b1;
            end
        end else begin
            unique case (r_step)
                ST_DEBOUNCE: begin
                    if (expired) begin
                        n_cols = i_column_bits;
                        n_step = (i_column_bits != '0) ? ST_DECODE : ST_IDLE;
                    end
                end
                ST_DECODE: begin
                    if (expired) begin
                        n_lines = i_line_bits;
                        if (dec_hit) begin
                            n_key  = dec_key;
                            n_step = ST_HELD;
                            n_mode = 1'b1;
                        end else begin
                            n_step = ST_IDLE;
                            n_mode = 1'b0;
                        end
                    end
                end
                ST_HELD: begin
                    if (expired) begin
                        if (!r_pressed) begin
                            n_pressed = 1'b1;
                            if (i_cfg.code_short_down != '0) begin
                                ev_valid = 1'b1;
                                ev_code  = i_cfg.code_short_down;
                            end
                        end
                        if (r_lines == i_line_bits) begin
                            if (i_cfg.long_target != '0 && r_hold < i_cfg.long_limit) begin
                                n_hold = hold_inc;
                                // long press wins a tie with the press event
                                if (hold_inc == i_cfg.long_target &&
                                    i_cfg.code_long_down != '0) begin
                                    ev_valid = 1'b1;
                                    ev_code  = i_cfg.code_long_down;
                                end
                            end
                            n_timer = i_cfg.filter_ticks;
                        end else begin
                            n_step  = ST_RELEASE;
                            n_timer = release_wait;
                        end
                    end
                end
                ST_RELEASE: begin
                    if (expired) begin
                        if (r_hold >= i_cfg.long_target) begin
                            if (i_cfg.code_long_up != '0) begin
                                ev_valid = 1'b1;
                                ev_code  = i_cfg.code_long_up;
                            end
                        end else if (i_cfg.code_short_up != '0) begin
                            ev_valid = 1'b1;
                            ev_code  = i_cfg.code_short_up;
                        end
                        n_pressed = 1'b0;
                        n_step    = ST_IDLE;
                        n_mode    = 1'b0;
                    end
                end
                default: begin
                    n_step = ST_IDLE;
                    n_cols = i_column_bits;
                    if (i_column_bits != '0) begin
                        n_step  = ST_DEBOUNCE;
                        n_hold  = '0;
                        n_timer = i_cfg.filter_ticks;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_result.event_valid     = ev_valid;
        o_result.event_code      = ev_code;
        o_result.key_index       = ev_valid ? n_key : '0;
        o_result.read_lines_mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_IDLE;
            r_timer   <= '0;
            r_hold    <= '0;
            r_key     <= '0;
            r_lines   <= '0;
            r_cols    <= '0;
            r_pressed <= 1'b0;
            r_mode    <= 1'b0;
        end else if (i_fire) begin
            r_step    <= n_step;
            r_timer   <= n_timer;
            r_hold    <= n_hold;
            r_key     <= n_key;
            r_lines   <= n_lines;
            r_cols    <= n_cols;
            r_pressed <= n_pressed;
            r_mode    <= n_mode;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/kpd_outbuf.sv
// Result register with a skid stage behind it.
`default_nettype none

module kpd_outbuf
    import kpd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_can_push,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data,
    output logic         o_skid_full
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free    = !r_out_valid || i_ready;
    assign o_can_push  = !r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_skid_full = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= i_data;
            end else begin
                r_out  <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/matrix_keypad_debounce_decoder.sv
// Top level of the 4x4 matrix keypad scanner with debounce and long-press events.
// Usage
//   Input channel (i_in_valid / o_in_ready): one word per tick or poll.
//   i_command low is a timer tick that counts the debounce timer down; high is
//   a poll carrying the sampled column and line bits.
//   Output channel (o_out_valid / i_out_ready): exactly one result word per
//   input word, in order: event flag, event code, key number and the drive
//   mode (o_read_lines_mode) the scan logic should apply next.
//   Each accepted word makes a single pass through the scan machine and the key
//   table; its result is registered in the result register when that is free and
//   the skid entry is empty, else in the skid entry. Throughput: one word per
//   cycle while o_in_ready is high.
//   Stalls: a result register plus one skid entry sit on the output, so one
//   more word is taken while a result waits; o_in_ready drops only when both
//   are full, and rises again as soon as the receiver takes a word.
//   Reset (synchronous, active low): scan machine idle, timers and counters
//   cleared, registers back to their defaults, output buffer empty.
//   Configuration: i_cfg_we writes register i_cfg_index at the edge; write
//   only while the block is idle. Unused indexes are ignored.
`default_nettype none

module matrix_keypad_debounce_decoder
    import kpd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [TIMER_W-1:0]     i_cfg_wdata,
    // input words
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_command,
    input  wire logic [COLUMN_BITS-1:0] i_column_bits,
    input  wire logic [LINE_BITS-1:0]   i_line_bits,
    // result words
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_event_valid,
    output logic [CODE_W-1:0]           o_event_code,
    output logic [KEY_W-1:0]            o_key_index,
    output logic                        o_read_lines_mode
);

    t_cfg    r_cfg;
    t_result fsm_result;
    t_result out_word;
    logic    fire;
    logic    skid_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_ticks    <= 16'd5;
            r_cfg.long_target     <= 16'd100;
            r_cfg.long_limit      <= 16'd1000;
            r_cfg.code_short_down <= 8'd1;
            r_cfg.code_short_up   <= 8'd2;
            r_cfg.code_long_down  <= 8'd3;
            r_cfg.code_long_up    <= 8'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FILTER_TICKS:    r_cfg.filter_ticks    <= i_cfg_wdata;
                REG_LONG_TARGET:     r_cfg.long_target     <= i_cfg_wdata;
                REG_LONG_LIMIT:      r_cfg.long_limit      <= i_cfg_wdata;
                REG_CODE_SHORT_DOWN: r_cfg.code_short_down <= i_cfg_wdata[CODE_W-1:0];
                REG_CODE_SHORT_UP:   r_cfg.code_short_up   <= i_cfg_wdata[CODE_W-1:0];
                REG_CODE_LONG_DOWN:  r_cfg.code_long_down  <= i_cfg_wdata[CODE_W-1:0];
                REG_CODE_LONG_UP:    r_cfg.code_long_up    <= i_cfg_wdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // A word is accepted whenever the skid entry is free
    assign fire = i_in_valid && o_in_ready;

    kpd_fsm u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_command     (i_command),
        .i_column_bits (i_column_bits),
        .i_line_bits   (i_line_bits),
        .i_cfg         (r_cfg),
        .o_result      (fsm_result)
    );

    kpd_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fire),
        .i_data      (fsm_result),
        .o_can_push  (o_in_ready),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (out_word),
        .o_skid_full (skid_full)
    );

    assign o_event_valid     = out_word.event_valid;
    assign o_event_code      = out_word.event_code;
    assign o_key_index       = out_word.key_index;
    assign o_read_lines_mode = out_word.read_lines_mode;

`ifndef SYNTHESIS
    // skid entry only fills behind a full result register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_full |-> o_out_valid)
        else $error("skid entry full while result register empty");

    // a reported event never carries a suppressed (zero) code
    a_event_code_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_valid) |-> (o_event_code != '0))
        else $error("event reported with zero code");

    // no event means code and key are cleared
    a_no_event_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_event_valid) |-> (o_event_code == '0 && o_key_index == '0))
        else $error("event fields set without an event");

    // after an accepted word a result is always valid at the next edge
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("accepted word produced no result");
`endif

endmodule

`default_nettype wire
